@@ rtl/abt_pkg.sv @@
// Package for the allocation Bloom tracker: field widths, hash constants,
// operation codes, state types and the hash status struct.
// No dependencies.
package abt_pkg;

    localparam int ADDR_W          = 64;
    localparam int BYTE_W          = 48;
    localparam int LIVE_W          = 32;
    localparam int OP_W            = 2;
    localparam int FILTER_BITS_DEF = 256;
    localparam int HASH_COUNT_DEF  = 4;
    localparam int HASH_CNT_W      = 3;

    localparam logic [63:0] MIX_GOLDEN = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL1   = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL2   = 64'h94d0_49bb_1331_11eb;

    localparam logic [63:0] HASH_SEED [4] = '{
        64'h9e37_79b9_7f4a_7c15,
        64'hbf58_476d_1ce4_e5b9,
        64'h94d0_49bb_1331_11eb,
        64'h27d4_eb2f_1656_67c5
    };

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 2'd0,
        OP_FREE       = 2'd1,
        OP_QUERY      = 2'd2,
        OP_PEAK_RESET = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_EXEC,
        S_DONE
    } ctrl_state_t;

    typedef enum logic [1:0] {
        H_IDLE,
        H_PRE,
        H_MUL1,
        H_MUL2
    } hash_state_t;

    typedef struct packed {
        logic idx_valid;
        logic done;
    } hash_sts_t;

endpackage

@@ rtl/abt_mul64.sv @@
// Iterative 64x64 multiplier returning the low 64 bits, one 32x32 partial
// product per cycle. Depends on abt_pkg.
module abt_mul64
    import abt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] mul_x;
    logic [31:0] mul_y;

    always_comb
    begin
        unique case (step_reg)
            2'd1:
            begin
                mul_x = a_reg[63:32];
                mul_y = b_reg[31:0];
            end
            2'd2:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[63:32];
            end
            default:
            begin
                mul_x = a_reg[31:0];
                mul_y = b_reg[31:0];
            end
        endcase
    end

    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next    = a;
            b_next    = b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = {32'b0, mul_x} * {32'b0, mul_y};
            step_next = step_reg + 2'd1;
            unique case (step_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = prod_reg;
                2'd2: acc_next = acc_reg + {prod_reg[31:0], 32'b0};
                2'd3:
                begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'b0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 2'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

@@ rtl/abt_hash_unit.sv @@
// Sequencer for the splitmix64 base hash and the seeded rehashes; emits one
// filter bit index per rehash. Depends on abt_pkg and abt_mul64.
module abt_hash_unit
    import abt_pkg::*;
#(
    parameter int HASH_COUNT = HASH_COUNT_DEF,
    parameter int IDX_W      = $clog2(FILTER_BITS_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [63:0]       key,
    output hash_sts_t         sts,
    output logic [IDX_W-1:0]  idx
);

    hash_state_t           state_reg, state_next;
    logic [63:0]           src_reg, src_next;
    logic [63:0]           base_reg, base_next;
    logic                  first_reg, first_next;
    logic [HASH_CNT_W-1:0] k_reg, k_next;
    logic [HASH_CNT_W-1:0] k_inc;
    logic [63:0]           pre_sum;
    logic [63:0]           pre_mix;
    logic [63:0]           mid_mix;
    logic [63:0]           fin_mix;
    logic                  mul_start;
    logic [63:0]           mul_a;
    logic [63:0]           mul_b;
    logic                  mul_done;
    logic [63:0]           mul_p;

    assign pre_sum = src_reg + MIX_GOLDEN;
    assign pre_mix = pre_sum ^ (pre_sum >> 30);
    assign mid_mix = mul_p ^ (mul_p >> 27);
    assign fin_mix = mul_p ^ (mul_p >> 31);
    assign k_inc   = k_reg + HASH_CNT_W'(1);

    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        base_next  = base_reg;
        first_next = first_reg;
        k_next     = k_reg;
        mul_start  = 1'b0;
        mul_a      = pre_mix;
        mul_b      = MIX_MUL1;
        sts        = '0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    src_next   = key;
                    first_next = 1'b1;
                    k_next     = '0;
                    state_next = H_PRE;
                end
            end
            H_PRE:
            begin
                mul_start  = 1'b1;
                state_next = H_MUL1;
            end
            H_MUL1:
            begin
                mul_a = mid_mix;
                mul_b = MIX_MUL2;
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    state_next = H_MUL2;
                end
            end
            H_MUL2:
            begin
                if (mul_done)
                begin
                    if (first_reg)
                    begin
                        base_next  = fin_mix;
                        src_next   = fin_mix + HASH_SEED[0];
                        first_next = 1'b0;
                        state_next = H_PRE;
                    end
                    else
                    begin
                        sts.idx_valid = 1'b1;
                        k_next        = k_inc;
                        if (k_inc == HASH_CNT_W'(HASH_COUNT))
                        begin
                            sts.done   = 1'b1;
                            state_next = H_IDLE;
                        end
                        else
                        begin
                            src_next   = base_reg + HASH_SEED[k_inc[1:0]];
                            state_next = H_PRE;
                        end
                    end
                end
            end
        endcase
    end

    assign idx = fin_mix[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            first_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            first_reg <= first_next;
            k_reg     <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg  <= src_next;
        base_reg <= base_next;
    end

    abt_mul64 u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

endmodule

@@ rtl/allocation_bloom_tracker.sv @@
// Allocation tracker: Bloom filter of live addresses plus byte totals and peaks.
// Nonzero-size alloc and query run HASH_COUNT+1 splitmix64 rounds (the base hash and one
// per rehash) on the shared 64-bit multiplier, each round a setup step and two products.
// Free, peak reset and zero-size alloc skip hashing.
// One transaction at a time; the next one is accepted while the previous result waits.
// Async active-low reset clears the filter, the totals, the peaks and the live count.
module allocation_bloom_tracker
    import abt_pkg::*;
#(
    parameter int FILTER_BITS = FILTER_BITS_DEF,
    parameter int HASH_COUNT  = HASH_COUNT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     op,
    input  logic [ADDR_W-1:0]   address,
    input  logic [BYTE_W-1:0]   requested_bytes,
    input  logic [BYTE_W-1:0]   reserved_bytes,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                maybe_present,
    output logic [LIVE_W-1:0]   live_buffers,
    output logic [BYTE_W-1:0]   allocated_now,
    output logic [BYTE_W-1:0]   allocated_peak,
    output logic [BYTE_W-1:0]   reserved_now,
    output logic [BYTE_W-1:0]   reserved_peak
);

    localparam int IDX_W = $clog2(FILTER_BITS);

    ctrl_state_t          state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [BYTE_W-1:0]    req_reg, req_next;
    logic [BYTE_W-1:0]    res_reg, res_next;
    logic                 present_reg, present_next;
    logic [FILTER_BITS-1:0] filter_reg, filter_next;
    logic [LIVE_W-1:0]    live_total_reg, live_total_next;
    logic [BYTE_W-1:0]    alloc_total_reg, alloc_total_next;
    logic [BYTE_W-1:0]    alloc_high_reg, alloc_high_next;
    logic [BYTE_W-1:0]    reserve_total_reg, reserve_total_next;
    logic [BYTE_W-1:0]    reserve_high_reg, reserve_high_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_present_reg;
    logic [LIVE_W-1:0]    out_live_reg;
    logic [BYTE_W-1:0]    out_alloc_reg;
    logic [BYTE_W-1:0]    out_alloc_high_reg;
    logic [BYTE_W-1:0]    out_reserve_reg;
    logic [BYTE_W-1:0]    out_reserve_high_reg;
    logic                 out_load;
    logic                 needs_hash;
    logic                 hash_start;
    hash_sts_t            hash_sts;
    logic [IDX_W-1:0]     hash_idx;
    logic [BYTE_W:0]      alloc_sum;
    logic [BYTE_W:0]      reserve_sum;
    logic [BYTE_W-1:0]    alloc_add;
    logic [BYTE_W-1:0]    reserve_add;
    logic [BYTE_W-1:0]    alloc_sub;
    logic [BYTE_W-1:0]    reserve_sub;

    assign in_ready   = (state_reg == S_IDLE);
    assign needs_hash = ((op_t'(op) == OP_ALLOC) && (requested_bytes != '0))
                        || (op_t'(op) == OP_QUERY);
    assign hash_start = in_valid && in_ready && needs_hash;

    assign alloc_sum   = {1'b0, alloc_total_reg} + {1'b0, req_reg};
    assign reserve_sum = {1'b0, reserve_total_reg} + {1'b0, res_reg};
    assign alloc_add   = alloc_sum[BYTE_W] ? '1 : alloc_sum[BYTE_W-1:0];
    assign reserve_add = reserve_sum[BYTE_W] ? '1 : reserve_sum[BYTE_W-1:0];
    assign alloc_sub   = (alloc_total_reg >= req_reg) ? alloc_total_reg - req_reg : '0;
    assign reserve_sub = (reserve_total_reg >= res_reg) ? reserve_total_reg - res_reg : '0;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next         = state_reg;
        op_next            = op_reg;
        addr_next          = addr_reg;
        req_next           = req_reg;
        res_next           = res_reg;
        present_next       = present_reg;
        filter_next        = filter_reg;
        live_total_next    = live_total_reg;
        alloc_total_next   = alloc_total_reg;
        alloc_high_next    = alloc_high_reg;
        reserve_total_next = reserve_total_reg;
        reserve_high_next  = reserve_high_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = op_t'(op);
                    addr_next    = address;
                    req_next     = requested_bytes;
                    res_next     = reserved_bytes;
                    present_next = (op_t'(op) == OP_QUERY);
                    state_next   = needs_hash ? S_HASH : S_EXEC;
                end
            end
            S_HASH:
            begin
                if (hash_sts.idx_valid)
                begin
                    if (op_reg == OP_ALLOC)
                    begin
                        filter_next[hash_idx] = 1'b1;
                    end
                    else
                    begin
                        present_next = present_reg & filter_reg[hash_idx];
                    end
                end
                if (hash_sts.done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (op_reg)
                    OP_ALLOC:
                    begin
                        if (req_reg != '0)
                        begin
                            alloc_total_next   = alloc_add;
                            reserve_total_next = reserve_add;
                            if (alloc_add > alloc_high_reg)
                            begin
                                alloc_high_next = alloc_add;
                            end
                            if (reserve_add > reserve_high_reg)
                            begin
                                reserve_high_next = reserve_add;
                            end
                            if (!(&live_total_reg))
                            begin
                                live_total_next = live_total_reg + LIVE_W'(1);
                            end
                        end
                    end
                    OP_FREE:
                    begin
                        if (addr_reg != '0)
                        begin
                            alloc_total_next   = alloc_sub;
                            reserve_total_next = reserve_sub;
                            if (live_total_reg != '0)
                            begin
                                live_total_next = live_total_reg - LIVE_W'(1);
                                if (live_total_reg == LIVE_W'(1))
                                begin
                                    filter_next = '0;
                                end
                            end
                        end
                    end
                    OP_QUERY:
                    begin
                        present_next = present_reg;
                    end
                    OP_PEAK_RESET:
                    begin
                        alloc_high_next   = alloc_total_reg;
                        reserve_high_next = reserve_total_reg;
                    end
                endcase
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            filter_reg        <= '0;
            live_total_reg    <= '0;
            alloc_total_reg   <= '0;
            alloc_high_reg    <= '0;
            reserve_total_reg <= '0;
            reserve_high_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            filter_reg        <= filter_next;
            live_total_reg    <= live_total_next;
            alloc_total_reg   <= alloc_total_next;
            alloc_high_reg    <= alloc_high_next;
            reserve_total_reg <= reserve_total_next;
            reserve_high_reg  <= reserve_high_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        req_reg     <= req_next;
        res_reg     <= res_next;
        present_reg <= present_next;
        if (out_load)
        begin
            out_present_reg      <= present_reg;
            out_live_reg         <= live_total_reg;
            out_alloc_reg        <= alloc_total_reg;
            out_alloc_high_reg   <= alloc_high_reg;
            out_reserve_reg      <= reserve_total_reg;
            out_reserve_high_reg <= reserve_high_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign maybe_present  = out_present_reg;
    assign live_buffers   = out_live_reg;
    assign allocated_now  = out_alloc_reg;
    assign allocated_peak = out_alloc_high_reg;
    assign reserved_now   = out_reserve_reg;
    assign reserved_peak  = out_reserve_high_reg;

    abt_hash_unit #(
        .HASH_COUNT (HASH_COUNT),
        .IDX_W      (IDX_W)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (address),
        .sts   (hash_sts),
        .idx   (hash_idx)
    );

    a_peak_covers_total: assert property (@(posedge clk) disable iff (!rst_n)
        (alloc_high_reg >= alloc_total_reg) && (reserve_high_reg >= reserve_total_reg))
        else $error("peak below current total");

    a_empty_filter: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && live_total_reg == '0) |-> (filter_reg == '0))
        else $error("filter holds bits with no live buffers");

    a_hash_done_in_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (hash_sts.idx_valid || hash_sts.done) |-> (state_reg == S_HASH))
        else $error("hash result outside hash phase");

    a_start_then_hash: assert property (@(posedge clk) disable iff (!rst_n)
        hash_start |=> (state_reg == S_HASH))
        else $error("hash started without entering hash phase");

endmodule

@@ bench/allocation_bloom_tracker_test.sv @@
// Self-checking testbench for allocation_bloom_tracker: a directed table and then
// random alloc/free/query/peak-reset traffic, each result checked against the table's
// expected values or a predictor. Depends on abt_pkg and the allocation_bloom_tracker RTL.
module allocation_bloom_tracker_test;
    import abt_pkg::*;

    localparam int          SLOT_W       = $clog2(FILTER_BITS_DEF);
    localparam int          RANDOM_ITEMS = 1200;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [47:0] BYTES_FULL   = '1;
    localparam logic [63:0] ADDR_ONES    = '1;
    localparam logic [63:0] ADDR_FIVES   = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ADDR_TENS    = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam logic [47:0] BYTES_FIVES  = 48'h5555_5555_5555;
    localparam logic [47:0] BYTES_TENS   = 48'hAAAA_AAAA_AAAA;

    typedef struct packed {
        logic              present;
        logic [LIVE_W-1:0] live;
        logic [BYTE_W-1:0] alloc_now;
        logic [BYTE_W-1:0] alloc_peak;
        logic [BYTE_W-1:0] resv_now;
        logic [BYTE_W-1:0] resv_peak;
    } tracker_result_t;

    typedef struct {
        op_t               code;
        logic [63:0]       addr;
        logic [47:0]       req;
        logic [47:0]       res;
        bit                typed;
        tracker_result_t   want;
    } directed_row_t;

    typedef struct {
        logic [63:0] addr;
        logic [47:0] req;
        logic [47:0] res;
    } live_block_t;

    localparam tracker_result_t ALL_ZERO = '0;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
    logic [BYTE_W-1:0] requested_bytes;
    logic [BYTE_W-1:0] reserved_bytes;
    logic              out_valid;
    logic              out_ready;
    logic              maybe_present;
    logic [LIVE_W-1:0] live_buffers;
    logic [BYTE_W-1:0] allocated_now;
    logic [BYTE_W-1:0] allocated_peak;
    logic [BYTE_W-1:0] reserved_now;
    logic [BYTE_W-1:0] reserved_peak;

    logic [FILTER_BITS_DEF-1:0] filter_bits;
    logic [LIVE_W-1:0]          model_live;
    logic [BYTE_W-1:0]          requested_total;
    logic [BYTE_W-1:0]          requested_peak;
    logic [BYTE_W-1:0]          reserved_total;
    logic [BYTE_W-1:0]          reserved_high;

    tracker_result_t expected_results[$];
    live_block_t     live_blocks[$];
    int              mismatch_count = 0;
    int              results_seen   = 0;
    int              cycle_count    = 0;
    bit              quiet_send     = 0;
    bit              draining       = 0;
    int              drain_at       = 8;

    directed_row_t directed_rows [25] = '{
        '{OP_QUERY,      64'h0,        48'd0,       48'd0,       1'b1, ALL_ZERO},
        '{OP_FREE,       64'h1000,     48'd10,      48'd16,      1'b1, ALL_ZERO},
        '{OP_PEAK_RESET, ADDR_ONES,    BYTES_FULL,  BYTES_FULL,  1'b1, ALL_ZERO},
        '{OP_ALLOC,      64'h1000,     48'd0,       BYTES_FULL,  1'b1, ALL_ZERO},
        '{OP_ALLOC,      ADDR_ONES,    48'd1,       48'd1,       1'b1,
          '{1'b0, 32'd1, 48'd1, 48'd1, 48'd1, 48'd1}},
        '{OP_QUERY,      ADDR_ONES,    48'd0,       48'd0,       1'b1,
          '{1'b1, 32'd1, 48'd1, 48'd1, 48'd1, 48'd1}},
        '{OP_ALLOC,      64'h1000,     BYTES_FULL,  BYTES_FULL,  1'b1,
          '{1'b0, 32'd2, BYTES_FULL, BYTES_FULL, BYTES_FULL, BYTES_FULL}},
        '{OP_ALLOC,      64'h0,        BYTES_FULL,  48'd1,       1'b1,
          '{1'b0, 32'd3, BYTES_FULL, BYTES_FULL, BYTES_FULL, BYTES_FULL}},
        '{OP_FREE,       64'h0,        48'd5,       48'd5,       1'b1,
          '{1'b0, 32'd3, BYTES_FULL, BYTES_FULL, BYTES_FULL, BYTES_FULL}},
        '{OP_FREE,       64'hDEAD,     48'h10,      48'h20,      1'b1,
          '{1'b0, 32'd2, BYTES_FULL - 48'h10, BYTES_FULL, BYTES_FULL - 48'h20, BYTES_FULL}},
        '{OP_PEAK_RESET, 64'h0,        48'd0,       48'd0,       1'b1,
          '{1'b0, 32'd2, BYTES_FULL - 48'h10, BYTES_FULL - 48'h10,
            BYTES_FULL - 48'h20, BYTES_FULL - 48'h20}},
        '{OP_QUERY,      64'h1000,     48'd0,       48'd0,       1'b0, ALL_ZERO},
        '{OP_QUERY,      64'h2000,     48'd0,       48'd0,       1'b0, ALL_ZERO},
        '{OP_FREE,       64'h1000,     BYTES_FULL,  BYTES_FULL,  1'b1,
          '{1'b0, 32'd1, 48'd0, BYTES_FULL - 48'h10, 48'd0, BYTES_FULL - 48'h20}},
        '{OP_FREE,       ADDR_ONES,    48'd1,       48'd1,       1'b1,
          '{1'b0, 32'd0, 48'd0, BYTES_FULL - 48'h10, 48'd0, BYTES_FULL - 48'h20}},
        '{OP_QUERY,      ADDR_ONES,    48'd0,       48'd0,       1'b1,
          '{1'b0, 32'd0, 48'd0, BYTES_FULL - 48'h10, 48'd0, BYTES_FULL - 48'h20}},
        '{OP_FREE,       64'h40,       48'd3,       48'd3,       1'b1,
          '{1'b0, 32'd0, 48'd0, BYTES_FULL - 48'h10, 48'd0, BYTES_FULL - 48'h20}},
        '{OP_PEAK_RESET, 64'h0,        48'd0,       48'd0,       1'b1, ALL_ZERO},
        '{OP_ALLOC,      ADDR_FIVES,   BYTES_TENS,  BYTES_FIVES, 1'b0, ALL_ZERO},
        '{OP_ALLOC,      ADDR_TENS,    BYTES_FIVES, BYTES_TENS,  1'b0, ALL_ZERO},
        '{OP_QUERY,      ADDR_FIVES,   48'd0,       48'd0,       1'b0, ALL_ZERO},
        '{OP_QUERY,      ADDR_TENS,    48'd0,       48'd0,       1'b0, ALL_ZERO},
        '{OP_FREE,       ADDR_FIVES,   BYTES_FIVES, BYTES_FIVES, 1'b0, ALL_ZERO},
        '{OP_FREE,       ADDR_TENS,    BYTES_TENS,  BYTES_TENS,  1'b0, ALL_ZERO},
        '{OP_QUERY,      ADDR_FIVES,   48'd0,       48'd0,       1'b0, ALL_ZERO}
    };

    allocation_bloom_tracker dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] splitmix(input logic [63:0] seed_in);
        logic [63:0] z;
        z = seed_in + MIX_GOLDEN;
        z = (z ^ (z >> 30)) * MIX_MUL1;
        z = (z ^ (z >> 27)) * MIX_MUL2;
        return z ^ (z >> 31);
    endfunction

    function automatic logic [SLOT_W-1:0] filter_slot(input logic [63:0] base, input int k);
        logic [63:0] h;
        h = splitmix(base + HASH_SEED[k]);
        return h[SLOT_W-1:0];
    endfunction

    function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? BYTES_FULL : s[47:0];
    endfunction

    function automatic tracker_result_t track_event(input op_t code, input logic [63:0] addr,
                                                    input logic [47:0] req,
                                                    input logic [47:0] res);
        tracker_result_t r;
        logic [63:0]     base;
        r = '0;
        base = splitmix(addr);
        case (code)
            OP_ALLOC:
            begin
                if (req != '0)
                begin
                    for (int k = 0; k < HASH_COUNT_DEF; k++)
                        filter_bits[filter_slot(base, k)] = 1'b1;
                    requested_total = sat_sum(requested_total, req);
                    if (requested_total > requested_peak)
                        requested_peak = requested_total;
                    reserved_total = sat_sum(reserved_total, res);
                    if (reserved_total > reserved_high)
                        reserved_high = reserved_total;
                    if (model_live != '1)
                        model_live = model_live + 32'd1;
                end
            end
            OP_FREE:
            begin
                if (addr != '0)
                begin
                    requested_total = (requested_total >= req) ? requested_total - req : '0;
                    reserved_total  = (reserved_total >= res) ? reserved_total - res : '0;
                    if (model_live != '0)
                    begin
                        model_live = model_live - 32'd1;
                        if (model_live == '0)
                            filter_bits = '0;
                    end
                end
            end
            OP_QUERY:
            begin
                r.present = 1'b1;
                for (int k = 0; k < HASH_COUNT_DEF; k++)
                    if (!filter_bits[filter_slot(base, k)])
                        r.present = 1'b0;
            end
            default:
            begin
                requested_peak = requested_total;
                reserved_high  = reserved_total;
            end
        endcase
        r.live       = model_live;
        r.alloc_now  = requested_total;
        r.alloc_peak = requested_peak;
        r.resv_now   = reserved_total;
        r.resv_peak  = reserved_high;
        return r;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [47:0] rand_bytes();
        logic [63:0] w;
        w = rand_word();
        return w[47:0];
    endfunction

    function automatic logic [47:0] rand_size();
        int          r;
        logic [47:0] s;
        r = $urandom_range(99);
        if (r < 80)
            s = 48'($urandom_range(1, 65536));
        else if (r < 95)
            s = rand_bytes();
        else
            s = BYTES_FULL;
        if (s == '0)
            s = 48'd1;
        return s;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at result %0d, %s: got %h, expected %h",
                 results_seen, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        tracker_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("transaction with nothing pending", 64'd1, 64'd0);
            else
            begin
                want = expected_results.pop_front();
                if (maybe_present !== want.present)
                    report_mismatch("maybe_present", 64'(maybe_present), 64'(want.present));
                if (live_buffers !== want.live)
                    report_mismatch("live_buffers", 64'(live_buffers), 64'(want.live));
                if (allocated_now !== want.alloc_now)
                    report_mismatch("allocated_now", 64'(allocated_now), 64'(want.alloc_now));
                if (allocated_peak !== want.alloc_peak)
                    report_mismatch("allocated_peak", 64'(allocated_peak),
                                    64'(want.alloc_peak));
                if (reserved_now !== want.resv_now)
                    report_mismatch("reserved_now", 64'(reserved_now), 64'(want.resv_now));
                if (reserved_peak !== want.resv_peak)
                    report_mismatch("reserved_peak", 64'(reserved_peak), 64'(want.resv_peak));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, a quiet window, and one long hold-off.
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= 500)
            begin
                held_off = 1'b1;
                out_ready = 1'b0;
                repeat (600) @(negedge clk);
            end
            if (results_seen >= 100 && results_seen < 350)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(99) >= 11);
        end
    end

    task automatic offer(input op_t code, input logic [63:0] addr, input logic [47:0] req,
                         input logic [47:0] res, input bit typed,
                         input tracker_result_t want);
        tracker_result_t predicted;
        while (!quiet_send && $urandom_range(99) < 11)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        op              = code;
        address         = addr;
        requested_bytes = req;
        reserved_bytes  = res;
        in_valid        = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = track_event(code, addr, req, res);
        expected_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic add_block(input logic [47:0] req, input logic [47:0] res);
        live_block_t blk;
        blk.addr = rand_word() & ~64'hF;
        if (blk.addr == '0)
            blk.addr = 64'h10;
        blk.req = req;
        blk.res = res;
        live_blocks.push_back(blk);
        offer(OP_ALLOC, blk.addr, blk.req, blk.res, 1'b0, ALL_ZERO);
    endtask

    task automatic release_block();
        int          slot;
        live_block_t blk;
        if (live_blocks.size() != 0)
        begin
            slot = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[slot];
            live_blocks.delete(slot);
        end
        else
        begin
            blk.addr = rand_word() | 64'h1;
            blk.req  = 48'($urandom_range(4096));
            blk.res  = 48'($urandom_range(4096));
        end
        offer(OP_FREE, blk.addr, blk.req, blk.res, 1'b0, ALL_ZERO);
    endtask

    task automatic random_event();
        int          pick;
        logic [63:0] a;
        pick = $urandom_range(99);
        // Grow the live set to a target, then drain until the count hits zero.
        if (draining && model_live == '0)
        begin
            draining = 1'b0;
            drain_at = $urandom_range(1, 24);
        end
        else if (!draining && live_blocks.size() >= drain_at)
            draining = 1'b1;

        if (pick < 55)
        begin
            if (draining || (pick >= 40 && live_blocks.size() != 0))
                release_block();
            else
                add_block(rand_size(), rand_size());
        end
        else if (pick < 80)
        begin
            if (live_blocks.size() != 0 && $urandom_range(1) == 1)
                a = live_blocks[$urandom_range(live_blocks.size() - 1)].addr;
            else
                a = rand_word();
            offer(OP_QUERY, a, rand_bytes(), rand_bytes(), 1'b0, ALL_ZERO);
        end
        else if (pick < 84)
            offer(OP_PEAK_RESET, rand_word(), rand_bytes(), rand_bytes(), 1'b0, ALL_ZERO);
        else
        begin
            case ($urandom_range(4))
                0: offer(OP_ALLOC, rand_word(), '0, rand_bytes(), 1'b0, ALL_ZERO);
                1: offer(OP_FREE, '0, rand_bytes(), rand_bytes(), 1'b0, ALL_ZERO);
                2: offer(OP_FREE, rand_word() | 64'h1, rand_size(), rand_size(), 1'b0,
                         ALL_ZERO);
                3: add_block(($urandom_range(1) == 1) ? BYTES_FULL : (rand_bytes() | 48'h1),
                             rand_bytes());
                default: offer(OP_QUERY, ($urandom_range(1) == 1) ? ADDR_ONES : 64'h0,
                               rand_bytes(), rand_bytes(), 1'b0, ALL_ZERO);
            endcase
        end
    endtask

    initial
    begin
        in_valid        = 1'b0;
        op              = OP_ALLOC;
        address         = '0;
        requested_bytes = '0;
        reserved_bytes  = '0;
        filter_bits     = '0;
        model_live      = '0;
        requested_total = '0;
        requested_peak  = '0;
        reserved_total  = '0;
        reserved_high   = '0;
        rst_n           = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].code, directed_rows[i].addr, directed_rows[i].req,
                  directed_rows[i].res, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_send = (n >= 250 && n < 500);
            if (n == 700)
                wait_drained();
            random_event();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
